// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/glzw_pkg.sv =====
`timescale 1ns / 1ps
package glzw_pkg;

    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int PIX_W             = 8;
    localparam int BYTE_W            = 8;
    localparam int LIT_W             = 4;
    localparam int CW_W              = 4;
    localparam int ACC_W             = 32;
    localparam int CNT_W             = 5;
    localparam int LIT_MIN           = 2;
    localparam int LIT_MAX           = 8;

    localparam logic [LIT_W-1:0] LIT_RESET = 4'd8;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_END   = 1'b1
    } req_type_t;

    function automatic logic [LIT_W-1:0] lit_sat(input logic [LIT_W-1:0] raw,
                                                 input logic [LIT_W-1:0] cap);
        logic [LIT_W-1:0] v;
        v = raw;
        if (v < LIT_W'(LIT_MIN))
            v = LIT_W'(LIT_MIN);
        if (v > LIT_W'(LIT_MAX))
            v = LIT_W'(LIT_MAX);
        if (v > cap)
            v = cap;
        return v;
    endfunction

endpackage

// ===== rtl/glzw_ram.sv =====
`timescale 1ns / 1ps
module glzw_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gif_lzw_encoder.sv =====
`timescale 1ns / 1ps
// GIF LZW encoder, one pixel index per request transaction, packed code bytes out.
// Request channel: req_valid/req_stall with req_type (pixel or end of image) and
// pixel_value. Output channel: byte_valid/byte_stall with out_byte, last_of_run
// (last byte caused by a request) and end_of_image (final byte of the image).
// Config channel: cfg_valid/cfg_ready with literal_bits; a write restarts the
// encoder, is taken only when nothing is in flight, and stalls requests meanwhile.
// A new request waits for the dictionary read followed by the code-to-slot verify
// read of the one before it, until the next prefix is known. A request whose codes
// complete bytes holds the next decision until its bytes have left the packer, one
// per cycle while byte_stall is low (up to 3 bytes per pixel, 4 for an end request).
// A request's first byte passes lookup stages p1 and p2, the packer and out_byte_reg.
// Reset: literal_bits 8, empty dictionary, empty packer. The dictionary needs no
// clearing pass: an entry counts only if its code lies below the next free code
// and the code-to-slot memory points back at the same slot.
// A stalled byte holds; the packer and then the request side stall behind it.
module gif_lzw_encoder
    import glzw_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic              req_type,
    input  logic [PIX_W-1:0]  pixel_value,
    output logic              byte_valid,
    input  logic              byte_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last_of_run,
    output logic              end_of_image,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LIT_W-1:0]  literal_bits
);

    localparam int CODE_W     = MAX_CODE_BITS;
    localparam int NFC_W      = CODE_W + 1;
    localparam int SLOT_W     = CODE_W + PIX_W;
    localparam int PAIR_W     = 2 * CODE_W;
    localparam int DICT_DEPTH = 1 << SLOT_W;
    localparam int REV_DEPTH  = 1 << CODE_W;
    localparam int LIT_CAP    = (CODE_W - 1 < LIT_MAX) ? CODE_W - 1 : LIT_MAX;

    localparam logic [LIT_W-1:0] LIT_CAP_V   = LIT_W'(LIT_CAP);
    localparam logic [CW_W-1:0]  MAX_WIDTH   = CW_W'(CODE_W);
    localparam logic [LIT_W-1:0] LIT_RST_U   = (LIT_RESET > LIT_CAP_V) ? LIT_CAP_V : LIT_RESET;
    localparam logic [NFC_W-1:0] NFC_RESET   = NFC_W'((1 << LIT_RST_U) + 2);
    localparam logic [CW_W-1:0]  WIDTH_RESET = CW_W'(LIT_RST_U + 1);
    localparam logic [CNT_W-1:0] BYTE_BITS   = CNT_W'(BYTE_W);

    // encoder state
    logic [LIT_W-1:0]  lit_reg, lit_next;
    logic [CODE_W-1:0] prefix_reg, prefix_next;
    logic              pv_reg, pv_next;
    logic [NFC_W-1:0]  nfc_reg, nfc_next;
    logic [CW_W-1:0]   width_reg, width_next;

    // packer
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              flush_reg, flush_next;

    // lookup pipeline
    logic              p1_valid_reg, p1_valid_next;
    logic              p1_end_reg;
    logic [PIX_W-1:0]  p1_pix_reg;
    logic [SLOT_W-1:0] p1_slot_reg;
    logic              p2_valid_reg, p2_valid_next;
    logic              p2_end_reg;
    logic [PIX_W-1:0]  p2_pix_reg;
    logic [SLOT_W-1:0] p2_slot_reg;
    logic [CODE_W-1:0] p2_code_reg;
    logic              fwd_reg, fwd_next;
    logic [CODE_W-1:0] fwd_data_reg;

    // output stage
    logic              byte_valid_reg, byte_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              last_reg;
    logic              eoi_reg;

    // derived from the literal width
    logic [LIT_W-1:0]  lit_u;
    logic [CODE_W-1:0] clear_code;
    logic [CODE_W-1:0] end_code;
    logic [NFC_W-1:0]  first_free;
    logic [CW_W-1:0]   init_width;
    logic [PIX_W-1:0]  pix_mask;
    logic [LIT_W-1:0]  cfg_lit_u;
    logic [NFC_W-1:0]  cfg_first_free;
    logic [CW_W-1:0]   cfg_init_width;

    // handshakes
    logic              accept;
    logic              cfg_write;
    logic              packer_idle;
    logic              dec;

    // decision
    logic [NFC_W-1:0]  wlim;
    logic [CODE_W-1:0] wmask;
    logic [NFC_W-1:0]  nfc_inc;
    logic              hit;
    logic [CODE_W-1:0] prefix_dec;
    logic              pv_dec;
    logic [NFC_W-1:0]  nfc_dec;
    logic [CW_W-1:0]   width_dec;
    logic [CODE_W-1:0] code_lo;
    logic [CODE_W-1:0] code_hi;
    logic              put_one;
    logic              put_two;
    logic              miss;
    logic              flush_set;
    logic [PAIR_W-1:0] pair;
    logic [CNT_W-1:0]  pair_len;

    // packer drain
    logic              can_emit;
    logic              emit;
    logic              final_byte;

    // memories
    logic [CODE_W-1:0] prefix_eff;
    logic [PIX_W-1:0]  pix_in;
    logic [SLOT_W-1:0] dict_raddr;
    logic [CODE_W-1:0] dict_rdata;
    logic              dict_we;
    logic [CODE_W-1:0] dict_code;
    logic [SLOT_W-1:0] rev_rdata;

    assign lit_u      = lit_sat(lit_reg, LIT_CAP_V);
    assign clear_code = CODE_W'(1) << lit_u;
    assign end_code   = clear_code + CODE_W'(1);
    assign first_free = (NFC_W'(1) << lit_u) + NFC_W'(2);
    assign init_width = lit_u + CW_W'(1);
    assign pix_mask   = {PIX_W{1'b1}} >> (LIT_W'(PIX_W) - lit_u);

    assign cfg_lit_u      = lit_sat(literal_bits, LIT_CAP_V);
    assign cfg_first_free = (NFC_W'(1) << cfg_lit_u) + NFC_W'(2);
    assign cfg_init_width = cfg_lit_u + CW_W'(1);

    assign packer_idle = (cnt_reg < BYTE_BITS) && !flush_reg;
    assign dec         = p2_valid_reg && packer_idle;
    assign req_stall   = p1_valid_reg || (p2_valid_reg && !packer_idle) || cfg_valid;
    assign accept      = req_valid && !req_stall;
    assign cfg_ready   = !p1_valid_reg && !p2_valid_reg && packer_idle;
    assign cfg_write   = cfg_valid && cfg_ready;

    // hit, miss, end of image, width growth and table restart for the item in the second stage
    always_comb
    begin
        wlim       = NFC_W'(1) << width_reg;
        wmask      = CODE_W'(wlim - NFC_W'(1));
        nfc_inc    = nfc_reg + NFC_W'(1);
        hit        = ({1'b0, p2_code_reg} >= first_free) &&
                     ({1'b0, p2_code_reg} < nfc_reg) &&
                     (rev_rdata == p2_slot_reg);
        prefix_dec = prefix_reg;
        pv_dec     = pv_reg;
        nfc_dec    = nfc_reg;
        width_dec  = width_reg;
        code_lo    = '0;
        code_hi    = '0;
        put_one    = 1'b0;
        put_two    = 1'b0;
        miss       = 1'b0;
        flush_set  = 1'b0;
        if (p2_end_reg)
        begin
            if (pv_reg)
            begin
                code_lo = prefix_reg;
                code_hi = end_code;
                put_two = 1'b1;
            end
            else
            begin
                code_lo = end_code;
                put_one = 1'b1;
            end
            flush_set  = 1'b1;
            prefix_dec = '0;
            pv_dec     = 1'b0;
            nfc_dec    = first_free;
            width_dec  = init_width;
        end
        else if (!pv_reg)
        begin
            prefix_dec = CODE_W'(p2_pix_reg);
            pv_dec     = 1'b1;
        end
        else if (hit)
        begin
            prefix_dec = p2_code_reg;
        end
        else
        begin
            miss       = 1'b1;
            code_lo    = prefix_reg;
            put_one    = 1'b1;
            prefix_dec = CODE_W'(p2_pix_reg);
            nfc_dec    = nfc_inc;
            if (nfc_inc >= wlim)
            begin
                if (width_reg < MAX_WIDTH)
                begin
                    width_dec = width_reg + CW_W'(1);
                end
                else
                begin
                    code_hi   = clear_code;
                    put_one   = 1'b0;
                    put_two   = 1'b1;
                    nfc_dec   = first_free;
                    width_dec = init_width;
                end
            end
        end
        pair = PAIR_W'(code_lo & wmask) | (PAIR_W'(code_hi & wmask) << width_reg);
        if (put_two)
            pair_len = CNT_W'({width_reg, 1'b0});
        else if (put_one)
            pair_len = CNT_W'(width_reg);
        else
            pair_len = '0;
    end

    assign dict_we    = dec && miss;
    assign prefix_eff = dec ? prefix_dec : prefix_reg;
    assign pix_in     = pixel_value & pix_mask;
    assign dict_raddr = {prefix_eff, pix_in};
    assign fwd_next   = accept && dict_we && (dict_raddr == p2_slot_reg);
    assign dict_code  = fwd_reg ? fwd_data_reg : dict_rdata;

    glzw_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DICT_DEPTH)
    ) u_dict (
        .clk   (clk),
        .we    (dict_we),
        .waddr (p2_slot_reg),
        .wdata (nfc_reg[CODE_W-1:0]),
        .re    (accept),
        .raddr (dict_raddr),
        .rdata (dict_rdata)
    );

    // code -> slot, proves a dictionary entry belongs to the current table
    glzw_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (REV_DEPTH)
    ) u_rev (
        .clk   (clk),
        .we    (dict_we),
        .waddr (nfc_reg[CODE_W-1:0]),
        .wdata (p2_slot_reg),
        .re    (p1_valid_reg),
        .raddr (dict_code),
        .rdata (rev_rdata)
    );

    // encoder state and pipeline occupancy
    always_comb
    begin
        lit_next    = lit_reg;
        prefix_next = prefix_reg;
        pv_next     = pv_reg;
        nfc_next    = nfc_reg;
        width_next  = width_reg;
        if (cfg_write)
        begin
            lit_next    = literal_bits;
            prefix_next = '0;
            pv_next     = 1'b0;
            nfc_next    = cfg_first_free;
            width_next  = cfg_init_width;
        end
        else if (dec)
        begin
            prefix_next = prefix_dec;
            pv_next     = pv_dec;
            nfc_next    = nfc_dec;
            width_next  = width_dec;
        end
        p1_valid_next = accept;
        if (p1_valid_reg)
            p2_valid_next = 1'b1;
        else if (dec)
            p2_valid_next = 1'b0;
        else
            p2_valid_next = p2_valid_reg;
    end

    // packer and output stage
    always_comb
    begin
        can_emit        = (cnt_reg >= BYTE_BITS) || (flush_reg && (cnt_reg != '0));
        emit            = can_emit && (!byte_valid_reg || !byte_stall);
        final_byte      = flush_reg && (cnt_reg <= BYTE_BITS);
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        flush_next      = flush_reg;
        byte_valid_next = byte_valid_reg;
        if (emit)
        begin
            byte_valid_next = 1'b1;
            if (final_byte)
            begin
                acc_next   = '0;
                cnt_next   = '0;
                flush_next = 1'b0;
            end
            else
            begin
                acc_next = acc_reg >> BYTE_W;
                cnt_next = cnt_reg - BYTE_BITS;
            end
        end
        else if (!byte_stall)
        begin
            byte_valid_next = 1'b0;
        end
        if (dec)
        begin
            acc_next   = acc_reg | (ACC_W'(pair) << cnt_reg);
            cnt_next   = cnt_reg + pair_len;
            flush_next = flush_set;
        end
        if (cfg_write)
        begin
            acc_next   = '0;
            cnt_next   = '0;
            flush_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg        <= LIT_RESET;
            prefix_reg     <= '0;
            pv_reg         <= 1'b0;
            nfc_reg        <= NFC_RESET;
            width_reg      <= WIDTH_RESET;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            flush_reg      <= 1'b0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            fwd_reg        <= 1'b0;
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            lit_reg        <= lit_next;
            prefix_reg     <= prefix_next;
            pv_reg         <= pv_next;
            nfc_reg        <= nfc_next;
            width_reg      <= width_next;
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            flush_reg      <= flush_next;
            p1_valid_reg   <= p1_valid_next;
            p2_valid_reg   <= p2_valid_next;
            fwd_reg        <= fwd_next;
            byte_valid_reg <= byte_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= nfc_reg[CODE_W-1:0];
        if (accept)
        begin
            p1_end_reg  <= (req_type == REQ_END);
            p1_pix_reg  <= pix_in;
            p1_slot_reg <= dict_raddr;
        end
        if (p1_valid_reg)
        begin
            p2_end_reg  <= p1_end_reg;
            p2_pix_reg  <= p1_pix_reg;
            p2_slot_reg <= p1_slot_reg;
            p2_code_reg <= dict_code;
        end
        if (emit)
        begin
            out_byte_reg <= acc_reg[BYTE_W-1:0];
            last_reg     <= final_byte || (!flush_reg && (cnt_reg < 2 * BYTE_BITS));
            eoi_reg      <= final_byte;
        end
    end

    assign byte_valid   = byte_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_run  = last_reg;
    assign end_of_image = eoi_reg;

endmodule

// ===== rtl/glzw_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module glzw_checker
    import glzw_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input logic              byte_valid,
    input logic              byte_stall,
    input logic [BYTE_W-1:0] out_byte,
    input logic              last_of_run,
    input logic              end_of_image,
    input logic              cfg_ready
);

    `ASSERT_NOW(a_eoi_is_last, clk, rst_n, byte_valid && end_of_image, last_of_run, "end_of_image byte not marked last")
    `ASSERT_NEXT(a_single_entry, clk, rst_n, req_valid && !req_stall, req_stall, "request taken while lookup busy")
    `ASSERT_NEXT(a_cfg_blocked, clk, rst_n, req_valid && !req_stall, !cfg_ready, "config open with a request in flight")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, byte_valid && byte_stall, byte_valid && $stable(out_byte) && $stable(last_of_run), "stalled byte changed")

endmodule

bind gif_lzw_encoder glzw_checker u_glzw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .end_of_image (end_of_image),
    .cfg_ready    (cfg_ready)
);
